### rtl/bjcc_pkg.sv
// Shared types and constants for the blocked jump-chain hop counter.
`timescale 1ns / 1ps
`default_nettype none

package bjcc_pkg;

    localparam int POS_W  = 10;
    localparam int JUMP_W = 11;
    localparam int SIZE_W = 11;
    localparam int CNT_W  = 11;

    localparam int SIZE_DEFAULT = 1024;

    localparam logic MODE_QUERY = 1'b0;
    localparam logic MODE_SET   = 1'b1;

    typedef struct packed {
        logic load;
        logic set_q;
        logic set_b;
        logic set_c;
        logic rb_issue;
        logic q_start;
        logic walk;
    } t_cmd;

    typedef struct packed {
        logic set_ok;
        logic rb_empty;
        logic rb_last;
        logic rb_pending;
        logic q_live;
        logic walk_more;
    } t_sts;

endpackage

`default_nettype wire

### rtl/bjcc_ctrl.sv
// Sequencing state machine for set rebuilds and query walks.
`timescale 1ns / 1ps
`default_nettype none

module bjcc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_mode,
    input  wire bjcc_pkg::t_sts i_sts,
    output bjcc_pkg::t_cmd     o_cmd,
    output logic               o_busy,
    output logic               o_strobe
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SET_Q   = 4'd1;
    localparam logic [3:0] ST_SET_B   = 4'd2;
    localparam logic [3:0] ST_SET_C   = 4'd3;
    localparam logic [3:0] ST_REBUILD = 4'd4;
    localparam logic [3:0] ST_DRAIN   = 4'd5;
    localparam logic [3:0] ST_Q_START = 4'd6;
    localparam logic [3:0] ST_WALK    = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign w_accept = i_start && (r_state == ST_IDLE);
    assign o_busy   = (r_state != ST_IDLE);
    assign o_strobe = (r_state == ST_DONE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = w_accept;
                if (w_accept) begin
                    n_state = (i_mode == bjcc_pkg::MODE_SET) ? ST_SET_Q : ST_Q_START;
                end
            end
            ST_SET_Q: begin
                o_cmd.set_q = 1'b1;
                n_state = i_sts.set_ok ? ST_SET_B : ST_IDLE;
            end
            ST_SET_B: begin
                o_cmd.set_b = 1'b1;
                n_state = ST_SET_C;
            end
            ST_SET_C: begin
                o_cmd.set_c = 1'b1;
                n_state = i_sts.rb_empty ? ST_IDLE : ST_REBUILD;
            end
            ST_REBUILD: begin
                o_cmd.rb_issue = 1'b1;
                if (i_sts.rb_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The final write-back lands on the edge that leaves this state.
                if (!i_sts.rb_pending) begin
                    n_state = ST_IDLE;
                end
            end
            ST_Q_START: begin
                o_cmd.q_start = 1'b1;
                n_state = i_sts.q_live ? ST_WALK : ST_DONE;
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (!i_sts.walk_more) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/bjcc_dp.sv
// Datapath: jump and block-exit memories, rebuild pipeline and query walker.
`timescale 1ns / 1ps
`default_nettype none

module bjcc_dp #(
    parameter int MAX_POSITIONS = 1024,
    parameter int BLOCK_LEN     = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire bjcc_pkg::t_cmd                  i_cmd,
    output bjcc_pkg::t_sts                       o_sts,
    input  wire logic                            i_cfg_we,
    input  wire logic [bjcc_pkg::SIZE_W-1:0]     i_cfg_data,
    input  wire logic [bjcc_pkg::POS_W-1:0]      i_position,
    input  wire logic [bjcc_pkg::JUMP_W-1:0]     i_jump_length,
    output logic      [bjcc_pkg::CNT_W-1:0]      o_hop_count
);

    localparam int AW  = $clog2(MAX_POSITIONS);
    localparam int CW  = ((AW > bjcc_pkg::SIZE_W) ? AW : bjcc_pkg::SIZE_W) + 2;
    localparam int HW  = $clog2(BLOCK_LEN + 1);
    localparam int SW  = bjcc_pkg::SIZE_W;
    localparam int PW  = bjcc_pkg::POS_W;
    localparam int JW  = bjcc_pkg::JUMP_W;
    localparam int NW  = bjcc_pkg::CNT_W;
    localparam int EW  = HW + SW;
    // Block index by reciprocal multiplication, exact for every position value.
    localparam int L2  = $clog2(BLOCK_LEN);
    localparam int SH  = PW + L2;
    localparam int RW  = SH + 1;
    localparam int MW  = PW + RW;
    localparam int RECIP_I = ((1 << SH) + BLOCK_LEN - 1) / BLOCK_LEN;
    localparam int SIZE_RST_I =
        (MAX_POSITIONS < bjcc_pkg::SIZE_DEFAULT) ? MAX_POSITIONS : bjcc_pkg::SIZE_DEFAULT;

    localparam logic [RW-1:0] RECIP    = RW'(RECIP_I);
    localparam logic [CW-1:0] MAX_C    = CW'(MAX_POSITIONS);
    localparam logic [CW-1:0] BLK_C    = CW'(BLOCK_LEN);
    localparam logic [SW-1:0] SIZE_RST = SW'(SIZE_RST_I);

    logic [JW-1:0] jmem [MAX_POSITIONS];
    logic [EW-1:0] emem [MAX_POSITIONS];

    logic [SW-1:0] r_size;
    logic [PW-1:0] r_pos;
    logic [JW-1:0] r_jump;
    logic [PW-1:0] r_quot;
    logic [PW-1:0] r_start;
    logic [CW-1:0] r_stop;
    logic [AW-1:0] r_i;
    logic          r_a_valid;
    logic [AW-1:0] r_a_i;
    logic          r_b_valid;
    logic [AW-1:0] r_b_i;
    logic          r_b_chain;
    logic [SW-1:0] r_b_tgt;
    logic [JW-1:0] r_jump_q;
    logic [EW-1:0] r_exit_q;
    logic          r_fwd_hit;
    logic [EW-1:0] r_fwd_data;
    logic [AW-1:0] r_cur;
    logic [NW-1:0] r_cnt;

    logic [CW-1:0] w_size_c;
    logic [CW-1:0] w_pos_c;
    logic [MW-1:0] w_prod;
    logic [CW-1:0] w_start_n;
    logic [CW-1:0] w_stop_raw;
    logic [CW-1:0] w_stop;
    logic [JW-1:0] w_jeff;
    logic [CW-1:0] w_nxt;
    logic          w_to_size;
    logic          w_far;
    logic [EW-1:0] w_fwd;
    logic [HW-1:0] w_fwd_hops;
    logic [SW-1:0] w_fwd_tgt;
    logic [CW-1:0] w_tgt_c;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [HW-1:0] w_wr_hops;
    logic [SW-1:0] w_wr_tgt;
    logic [AW-1:0] w_erd_addr;
    logic [NW:0]   w_sum;
    logic [NW-1:0] w_cnt_n;
    logic          w_set_ok;
    logic          w_walk_more;
    logic [SW-1:0] w_cfg_size;
    logic          w_jwe;

    assign w_size_c = CW'(r_size);
    assign w_pos_c  = CW'(r_pos);
    assign w_set_ok = (w_pos_c < MAX_C);
    assign w_jwe    = i_cmd.set_q && w_set_ok;

    // Block start and stop for the set being rebuilt.
    assign w_prod     = MW'(r_pos) * MW'(RECIP);
    assign w_start_n  = CW'(r_quot) * BLK_C;
    assign w_stop_raw = CW'(r_start) + BLK_C;
    assign w_stop     = (w_stop_raw > w_size_c) ? w_size_c : w_stop_raw;

    // Rebuild stage A: jump data for r_a_i has arrived.
    assign w_jeff    = (r_jump_q == '0) ? JW'(1) : r_jump_q;
    assign w_nxt     = CW'(r_a_i) + CW'(w_jeff);
    assign w_to_size = (w_nxt >= w_size_c);
    assign w_far     = (w_nxt >= r_stop);

    // Exit data, with the write that shared the read edge folded back in.
    assign w_fwd      = r_fwd_hit ? r_fwd_data : r_exit_q;
    assign w_fwd_hops = w_fwd[EW-1:SW];
    assign w_fwd_tgt  = w_fwd[SW-1:0];
    assign w_tgt_c    = CW'(w_fwd_tgt);

    // Rebuild stage B: write back the entry for r_b_i.
    assign w_wr_en   = r_b_valid;
    assign w_wr_addr = r_b_i;
    assign w_wr_hops = r_b_chain ? (w_fwd_hops + HW'(1)) : HW'(1);
    assign w_wr_tgt  = r_b_chain ? w_fwd_tgt : r_b_tgt;

    always_comb begin
        if (i_cmd.q_start) begin
            w_erd_addr = AW'(r_pos);
        end else if (i_cmd.walk) begin
            w_erd_addr = AW'(w_fwd_tgt);
        end else begin
            w_erd_addr = AW'(w_nxt);
        end
    end

    // Query walk step.
    assign w_sum       = (NW + 1)'(r_cnt) + (NW + 1)'(w_fwd_hops);
    assign w_cnt_n     = w_sum[NW] ? '1 : w_sum[NW-1:0];
    assign w_walk_more = (w_tgt_c > CW'(r_cur)) && (w_tgt_c < w_size_c) && (w_tgt_c < MAX_C);

    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg_size = SW'(1);
        end else if (CW'(i_cfg_data) > MAX_C) begin
            w_cfg_size = SW'(MAX_C);
        end else begin
            w_cfg_size = i_cfg_data;
        end
    end

    assign o_sts.set_ok     = w_set_ok;
    assign o_sts.rb_empty   = (w_stop <= CW'(r_start));
    assign o_sts.rb_last    = (r_i == AW'(r_start));
    assign o_sts.rb_pending = r_a_valid;
    assign o_sts.q_live     = (w_pos_c < w_size_c) && (w_pos_c < MAX_C);
    assign o_sts.walk_more  = w_walk_more;

    assign o_hop_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (w_jwe) begin
            jmem[AW'(r_pos)] <= r_jump;
        end
        r_jump_q <= jmem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            emem[w_wr_addr] <= {w_wr_hops, w_wr_tgt};
        end
        r_exit_q <= emem[w_erd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= SIZE_RST;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= w_cfg_size;
            end
            r_a_valid <= i_cmd.rb_issue;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos  <= i_position;
            r_jump <= (i_jump_length == '0) ? JW'(1) : i_jump_length;
        end
        if (i_cmd.set_q) begin
            r_quot <= PW'(w_prod >> SH);
        end
        if (i_cmd.set_b) begin
            r_start <= PW'(w_start_n);
        end
        if (i_cmd.set_c) begin
            r_stop <= w_stop;
            r_i    <= AW'(w_stop - CW'(1));
        end else if (i_cmd.rb_issue) begin
            r_i <= r_i - AW'(1);
        end
        r_a_i      <= r_i;
        r_b_i      <= r_a_i;
        r_b_chain  <= !w_to_size && !w_far;
        r_b_tgt    <= w_to_size ? r_size : SW'(w_nxt);
        r_fwd_hit  <= w_wr_en && (w_wr_addr == w_erd_addr);
        r_fwd_data <= {w_wr_hops, w_wr_tgt};
        if (i_cmd.q_start) begin
            r_cur <= AW'(r_pos);
            r_cnt <= '0;
        end else if (i_cmd.walk) begin
            r_cnt <= w_cnt_n;
            if (w_walk_more) begin
                r_cur <= AW'(w_fwd_tgt);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/blocked_jump_chain_counter_top.sv
// Top level of the blocked jump-chain hop counter.
//
// A set (mode 1) stores one jump length and rebuilds the exit entries of its block, one
// entry per cycle from right to left through a three-stage memory pipeline, with fewer
// entries when the block is cut short by size_in_use, and a set beyond MAX_POSITIONS is
// dropped. A query (mode 0) walks one block exit per cycle, limited by the single read
// port of the exit memory. Its result appears on o_hop_count with o_strobe high for
// exactly one cycle and the receiver cannot stall it. Sets give no result. Write
// size_in_use only while busy is low, then reload every position before querying.
`timescale 1ns / 1ps
`default_nettype none

module blocked_jump_chain_counter_top #(
    parameter int MAX_POSITIONS = 1024,
    parameter int BLOCK_LEN     = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_mode,
    input  wire logic [bjcc_pkg::POS_W-1:0]  i_position,
    input  wire logic [bjcc_pkg::JUMP_W-1:0] i_jump_length,
    output logic                             o_strobe,
    output logic      [bjcc_pkg::CNT_W-1:0]  o_hop_count,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [bjcc_pkg::SIZE_W-1:0] i_cfg_data
);

    bjcc_pkg::t_cmd w_cmd;
    bjcc_pkg::t_sts w_sts;

    assign o_cfg_ready = ~busy;

    bjcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_mode),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    bjcc_dp #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .BLOCK_LEN     (BLOCK_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_position    (i_position),
        .i_jump_length (i_jump_length),
        .o_hop_count   (o_hop_count)
    );

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.set_q, w_cmd.set_b, w_cmd.set_c,
                  w_cmd.rb_issue, w_cmd.q_start, w_cmd.walk}))
        else $error("more than one datapath command active");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy && $past(busy)))
        else $error("result strobe without a query in progress");
`endif

endmodule

`default_nettype wire

### tb/sv/hop_count_checker.sv
// Checker that predicts the hop counts of the blocked jump-chain counter and compares them.
`timescale 1ns / 1ps

module hop_count_checker #(
    parameter int MAX_POSITIONS = 1024,
    parameter int BLOCK_LEN     = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic                        i_mode,
    input  wire logic [bjcc_pkg::POS_W-1:0]  i_position,
    input  wire logic [bjcc_pkg::JUMP_W-1:0] i_jump_length,
    input  wire logic                        i_strobe,
    input  wire logic [bjcc_pkg::CNT_W-1:0]  i_hop_count,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_ready,
    input  wire logic [bjcc_pkg::SIZE_W-1:0] i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam int   JUMP_W       = bjcc_pkg::JUMP_W;
    localparam int   SIZE_W       = bjcc_pkg::SIZE_W;
    localparam int   CNT_W        = bjcc_pkg::CNT_W;
    localparam int   SIZE_DEFAULT = bjcc_pkg::SIZE_DEFAULT;
    localparam logic MODE_SET     = bjcc_pkg::MODE_SET;

    localparam int HOPS_W  = $clog2(BLOCK_LEN + 1);
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    int                 size_in_use;
    logic [JUMP_W-1:0]  jump_len_mem   [MAX_POSITIONS];
    logic [HOPS_W-1:0]  block_hops_mem [MAX_POSITIONS];
    logic [SIZE_W-1:0]  block_exit_mem [MAX_POSITIONS];
    logic [CNT_W-1:0]   hop_counts_due [$];
    logic [CNT_W-1:0]   oldest_due;
    int                 fails = 0;
    int                 due_count = 0;
    int                 k;

    assign o_fail_count = fails;
    assign o_pending    = due_count;

    function automatic int clamp_size(input logic [SIZE_W-1:0] value);
        if (value == '0) return 1;
        if (value > MAX_POSITIONS) return MAX_POSITIONS;
        return int'(value);
    endfunction

    // Walks the block from its right-hand end, so that each entry can lean on the one it jumps to.
    task automatic rebuild_exit_block(input int pos);
        int first, stop, i, jmp, nxt;
        first = (pos / BLOCK_LEN) * BLOCK_LEN;
        stop  = first + BLOCK_LEN;
        if (stop > size_in_use) stop = size_in_use;
        for (i = stop - 1; i >= first; i--) begin
            jmp = (jump_len_mem[i] == '0) ? 1 : int'(jump_len_mem[i]);
            nxt = i + jmp;
            if (nxt >= size_in_use) begin
                block_hops_mem[i] = HOPS_W'(1);
                block_exit_mem[i] = SIZE_W'(size_in_use);
            end else if (nxt >= stop) begin
                block_hops_mem[i] = HOPS_W'(1);
                block_exit_mem[i] = SIZE_W'(nxt);
            end else begin
                block_hops_mem[i] = block_hops_mem[nxt] + HOPS_W'(1);
                block_exit_mem[i] = block_exit_mem[nxt];
            end
        end
    endtask

    function automatic logic [CNT_W-1:0] count_hops_from(input int start_pos);
        int p, cnt, nx;
        p   = start_pos;
        cnt = 0;
        while (p < size_in_use && p < MAX_POSITIONS) begin
            cnt += int'(block_hops_mem[p]);
            if (cnt > CNT_MAX) cnt = CNT_MAX;
            nx = int'(block_exit_mem[p]);
            // An exit that does not move forward ends the walk where it stands.
            if (nx <= p) break;
            p = nx;
        end
        return CNT_W'(cnt);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            size_in_use = SIZE_DEFAULT;
            for (k = 0; k < MAX_POSITIONS; k++) begin
                jump_len_mem[k]   = '0;
                block_hops_mem[k] = '0;
                block_exit_mem[k] = '0;
            end
            hop_counts_due.delete();
        end else begin
            // A result beat belongs to an earlier query, so it is matched before any new one.
            if (i_strobe) begin
                if (hop_counts_due.size() == 0) begin
                    $error("hop_count: result %0d arrived with none expected", i_hop_count);
                    fails++;
                end else begin
                    oldest_due = hop_counts_due.pop_front();
                    if (i_hop_count !== oldest_due) begin
                        $error("hop_count mismatch: expected %0d, actual %0d",
                               oldest_due, i_hop_count);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) size_in_use = clamp_size(i_cfg_data);
            if (start && !busy) begin
                if (i_mode == MODE_SET) begin
                    if (int'(i_position) < MAX_POSITIONS) begin
                        jump_len_mem[i_position] = (i_jump_length == '0) ? JUMP_W'(1)
                                                                          : i_jump_length;
                        rebuild_exit_block(int'(i_position));
                    end
                end else begin
                    hop_counts_due.push_back(count_hops_from(int'(i_position)));
                end
            end
        end
        due_count = hop_counts_due.size();
    end

endmodule

### tb/sv/tb_blocked_jump_chain_counter_top.sv
// Testbench top: clock, reset, stimulus and verdict for the blocked jump-chain hop counter.
`timescale 1ns / 1ps

module tb_blocked_jump_chain_counter_top;

    localparam int   POS_W        = bjcc_pkg::POS_W;
    localparam int   JUMP_W       = bjcc_pkg::JUMP_W;
    localparam int   SIZE_W       = bjcc_pkg::SIZE_W;
    localparam int   CNT_W        = bjcc_pkg::CNT_W;
    localparam int   SIZE_DEFAULT = bjcc_pkg::SIZE_DEFAULT;
    localparam logic MODE_QUERY   = bjcc_pkg::MODE_QUERY;
    localparam logic MODE_SET     = bjcc_pkg::MODE_SET;

    localparam int MAX_POSITIONS = 1024;
    localparam int BLOCK_LEN     = 32;
    localparam int CYCLE_LIMIT   = 800_000;
    localparam int NUM_PHASES    = 6;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               start         = 1'b0;
    logic               i_mode        = MODE_QUERY;
    logic [POS_W-1:0]   i_position    = '0;
    logic [JUMP_W-1:0]  i_jump_length = '0;
    logic               i_cfg_valid   = 1'b0;
    logic [SIZE_W-1:0]  i_cfg_data    = '0;
    logic               busy;
    logic               o_strobe;
    logic [CNT_W-1:0]   o_hop_count;
    logic               o_cfg_ready;

    int fail_count;
    int pending_results;
    int cycles     = 0;
    int cur_size   = SIZE_DEFAULT;
    int burst_left = 0;

    // Size written in each phase, whether the table is reloaded after it, and random item count.
    // Sizes 0 and 2047 lie outside the range and are clamped; the fourth and fifth phases keep
    // stale entries on purpose.
    int phase_size   [NUM_PHASES] = '{0, 45, 2047, 600, 1024, 33};
    bit phase_reload [NUM_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    int phase_items  [NUM_PHASES] = '{40, 150, 200, 150, 100, 100};

    always #5 i_clk = ~i_clk;

    blocked_jump_chain_counter_top #(
        .MAX_POSITIONS(MAX_POSITIONS),
        .BLOCK_LEN    (BLOCK_LEN)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_position   (i_position),
        .i_jump_length(i_jump_length),
        .o_strobe     (o_strobe),
        .o_hop_count  (o_hop_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    hop_count_checker #(
        .MAX_POSITIONS(MAX_POSITIONS),
        .BLOCK_LEN    (BLOCK_LEN)
    ) hop_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_position   (i_position),
        .i_jump_length(i_jump_length),
        .i_strobe     (o_strobe),
        .i_hop_count  (o_hop_count),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly short jumps for long walks, now and then one that leaves the table at once.
    function automatic int random_jump();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 4);
            6, 7, 8:          return $urandom_range(0, 64);
            default:          return $urandom_range(0, 2047);
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_item(input logic mode, input int pos, input int jmp);
        logic was_busy;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 25);
        end
        burst_left--;
        i_mode        <= mode;
        i_position    <= POS_W'(pos);
        i_jump_length <= JUMP_W'(jmp);
        start         <= 1'b1;
        do begin
            @(negedge i_clk);
            was_busy = busy;
            @(posedge i_clk);
        end while (was_busy);
    endtask

    task automatic write_size(input int value);
        logic was_ready;
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
        // A set leaves no result behind, so its rebuild may still be running here.
        repeat (BLOCK_LEN + 10) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= SIZE_W'(value);
        do begin
            @(negedge i_clk);
            was_ready = o_cfg_ready;
            @(posedge i_clk);
        end while (!was_ready);
        i_cfg_valid <= 1'b0;
        cur_size   = (value < 1) ? 1 : (value > MAX_POSITIONS) ? MAX_POSITIONS : value;
        burst_left = 0;
    endtask

    initial begin
        int ph, p, n, pos;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_size(phase_size[ph]);
            // Loading in rising order means each block's last set sees all its jumps written.
            if (phase_reload[ph]) begin
                for (p = 0; p < cur_size; p++) begin
                    send_item(MODE_SET, p,
                              (ph == 1 || ph == 5) ? $urandom_range(0, 1) : random_jump());
                end
            end

            if (ph == 0) begin
                // With a size of one, every other position lies past the end of the table.
                send_item(MODE_QUERY, 0, 0);
                send_item(MODE_QUERY, 1, 2047);
                send_item(MODE_QUERY, 1023, 0);
                send_item(MODE_SET, 0, 0);
                send_item(MODE_QUERY, 0, 0);
                send_item(MODE_SET, 1023, 1024);
                send_item(MODE_SET, 5, 3);
                send_item(MODE_SET, 0, 2047);
                send_item(MODE_QUERY, 0, 1);
                send_item(MODE_QUERY, 1023, 0);
            end else if (ph == 1) begin
                // A chain of unit jumps across a full block and a short final block.
                send_item(MODE_QUERY, 0, 0);
                send_item(MODE_QUERY, 31, 0);
                send_item(MODE_QUERY, 32, 0);
                send_item(MODE_QUERY, 44, 0);
                send_item(MODE_QUERY, 45, 0);
                send_item(MODE_SET, 31, 0);
                send_item(MODE_SET, 10, 1024);
                send_item(MODE_SET, 40, 4);
                send_item(MODE_QUERY, 0, 0);
                send_item(MODE_QUERY, 10, 0);
                send_item(MODE_QUERY, 38, 0);
                send_item(MODE_SET, 50, 1);
                send_item(MODE_QUERY, 33, 0);
            end

            for (n = 0; n < phase_items[ph]; n++) begin
                pos = ($urandom_range(0, 4) != 0) ? $urandom_range(0, cur_size - 1)
                                                  : $urandom_range(0, MAX_POSITIONS - 1);
                send_item($urandom_range(0, 1) ? MODE_SET : MODE_QUERY, pos, random_jump());
            end
        end

        start <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
        repeat (2 * BLOCK_LEN + 10) @(posedge i_clk);
        if (fail_count == 0 && pending_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
